@@ rtl/core/pidc_pkg.sv @@
package pidc_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_TARGET_LEVEL = 3'd0;
    localparam logic [2:0] REG_GAIN_PROP    = 3'd1;
    localparam logic [2:0] REG_GAIN_INTEG   = 3'd2;
    localparam logic [2:0] REG_GAIN_DERIV   = 3'd3;
    localparam logic [2:0] REG_INTEG_LIMIT  = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Reset values of the configuration registers
    localparam logic [9:0]  TARGET_RST = 10'd500;
    localparam logic [23:0] GPROP_RST  = 24'd131072;
    localparam logic [23:0] GINTEG_RST = 24'd3277;
    localparam logic [23:0] GDERIV_RST = 24'd32768;
    localparam logic [18:0] LIMIT_RST  = 19'd500000;

    // Shared multiplier operand width (signed)
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [MUL_W-1:0] K_MILLI = 33'sd1000;
    localparam logic signed [MUL_W-1:0] K_MICRO = 33'sd1000000;

    localparam logic [7:0] DRIVE_MAX = 8'd255;

    // Quotient bits produced by the restoring divide (one saturation bit)
    localparam int          DIV_STEPS    = 9;
    localparam logic [3:0]  DIV_LAST_CNT = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_M8,
        ST_M9,
        ST_M10,
        ST_M11,
        ST_M12,
        ST_DIV,
        ST_OUT
    } state_t;

    // Operand pair for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_ERR_EL,
        MUL_GP_EL,
        MUL_GI_EL,
        MUL_ERR_K,
        MUL_DERR_M,
        MUL_GLO_E,
        MUL_GHI_E,
        MUL_HLO_A,
        MUL_HHI_A,
        MUL_GD_D,
        MUL_EL_K
    } mul_sel_t;

    // Destination of the registered product
    typedef enum logic [3:0] {
        WR_NONE,
        WR_ACC,
        WR_G,
        WR_H,
        WR_E1K,
        WR_D1M,
        WR_NUM,
        WR_NUM_HI,
        WR_DEN
    } wr_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        wr_sel_t  wr_sel;
        logic     div_step;
        logic     commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic el_zero;
        logic out_free;
    } ctrl_sts_t;

endpackage

@@ rtl/core/pidc_if.sv @@
interface pidc_meas_if;
    logic       valid;
    logic       ready;
    logic [9:0] sample;
    logic [15:0] elapsed_ms;

    modport source (output valid, output sample, output elapsed_ms, input ready);
    modport sink (input valid, input sample, input elapsed_ms, output ready);
endinterface

interface pidc_duty_if;
    logic       valid;
    logic       ready;
    logic [7:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

@@ rtl/core/pidc_ctrl.sv @@
module pidc_ctrl
    import pidc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t     state_reg;
    state_t     state_next;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;

    // State and divide counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Sequence the multiplies, the divide and the result hand-off
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.mul_sel  = MUL_NONE;
        cmd.wr_sel   = WR_NONE;
        cmd.div_step = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    // drop an item with zero elapsed time
                    if (!sts.el_zero)
                        state_next = ST_M1;
                end
            end
            ST_M1:
            begin
                cmd.mul_sel = MUL_ERR_EL;
                state_next  = ST_M2;
            end
            ST_M2:
            begin
                cmd.mul_sel = MUL_GP_EL;
                cmd.wr_sel  = WR_ACC;
                state_next  = ST_M3;
            end
            ST_M3:
            begin
                cmd.mul_sel = MUL_GI_EL;
                cmd.wr_sel  = WR_G;
                state_next  = ST_M4;
            end
            ST_M4:
            begin
                cmd.mul_sel = MUL_ERR_K;
                cmd.wr_sel  = WR_H;
                state_next  = ST_M5;
            end
            ST_M5:
            begin
                cmd.mul_sel = MUL_DERR_M;
                cmd.wr_sel  = WR_E1K;
                state_next  = ST_M6;
            end
            ST_M6:
            begin
                cmd.mul_sel = MUL_GLO_E;
                cmd.wr_sel  = WR_D1M;
                state_next  = ST_M7;
            end
            ST_M7:
            begin
                cmd.mul_sel = MUL_GHI_E;
                cmd.wr_sel  = WR_NUM;
                state_next  = ST_M8;
            end
            ST_M8:
            begin
                cmd.mul_sel = MUL_HLO_A;
                cmd.wr_sel  = WR_NUM_HI;
                state_next  = ST_M9;
            end
            ST_M9:
            begin
                cmd.mul_sel = MUL_HHI_A;
                cmd.wr_sel  = WR_NUM;
                state_next  = ST_M10;
            end
            ST_M10:
            begin
                cmd.mul_sel = MUL_GD_D;
                cmd.wr_sel  = WR_NUM_HI;
                state_next  = ST_M11;
            end
            ST_M11:
            begin
                cmd.mul_sel = MUL_EL_K;
                cmd.wr_sel  = WR_NUM;
                state_next  = ST_M12;
            end
            ST_M12:
            begin
                cmd.wr_sel = WR_DEN;
                cnt_next   = DIV_LAST_CNT;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_OUT;
                else
                    cnt_next = cnt_reg - 4'd1;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/pidc_dp.sv @@
module pidc_dp
    import pidc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [9:0]            in_sample,
    input  logic [15:0]           in_elapsed_ms,
    input  ctrl_cmd_t             cmd,
    output ctrl_sts_t             sts,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [7:0]            out_drive
);

    // Configuration registers
    logic [9:0]  target_reg;
    logic [23:0] gprop_reg;
    logic [23:0] ginteg_reg;
    logic [23:0] gderiv_reg;
    logic [18:0] limit_reg;

    // Loop state
    logic signed [19:0] accum_reg;
    logic signed [10:0] last_reg;

    // Per-item working registers
    logic [15:0]               el_reg;
    logic signed [10:0]        err_reg;
    logic signed [19:0]        acc_new_reg;
    logic [39:0]               g_reg;
    logic [39:0]               h_reg;
    logic signed [20:0]        e1k_reg;
    logic signed [31:0]        d1m_reg;
    logic signed [63:0]        num_reg;
    logic [49:0]               dsh_reg;
    logic                      pos_reg;
    logic [DIV_STEPS-1:0]      q_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    // Output register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] drive_reg;

    logic signed [11:0]       derr;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [27:0]       acc_sum;
    logic signed [27:0]       lim_pos;
    logic signed [27:0]       lim_neg;
    logic signed [19:0]       acc_clamp;
    logic [63:0]              div_rem;
    logic                     div_fit;
    logic [7:0]               drive_next;

    assign derr = {err_reg[10], err_reg} - {last_reg[10], last_reg};

    // Select the multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_ERR_EL:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed({17'd0, el_reg});
            end
            MUL_GP_EL:
            begin
                mul_a = $signed({9'd0, gprop_reg});
                mul_b = $signed({17'd0, el_reg});
            end
            MUL_GI_EL:
            begin
                mul_a = $signed({9'd0, ginteg_reg});
                mul_b = $signed({17'd0, el_reg});
            end
            MUL_ERR_K:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = K_MILLI;
            end
            MUL_DERR_M:
            begin
                mul_a = MUL_W'(derr);
                mul_b = K_MICRO;
            end
            MUL_GLO_E:
            begin
                mul_a = $signed({13'd0, g_reg[19:0]});
                mul_b = MUL_W'(e1k_reg);
            end
            MUL_GHI_E:
            begin
                mul_a = $signed({13'd0, g_reg[39:20]});
                mul_b = MUL_W'(e1k_reg);
            end
            MUL_HLO_A:
            begin
                mul_a = $signed({13'd0, h_reg[19:0]});
                mul_b = MUL_W'(acc_new_reg);
            end
            MUL_HHI_A:
            begin
                mul_a = $signed({13'd0, h_reg[39:20]});
                mul_b = MUL_W'(acc_new_reg);
            end
            MUL_GD_D:
            begin
                mul_a = $signed({9'd0, gderiv_reg});
                mul_b = MUL_W'(d1m_reg);
            end
            MUL_EL_K:
            begin
                mul_a = $signed({17'd0, el_reg});
                mul_b = K_MILLI;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Clamp the updated accumulator to the symmetric limit
    assign acc_sum = 28'(accum_reg) + $signed(prod_reg[27:0]);
    assign lim_pos = $signed({9'd0, limit_reg});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (acc_sum > lim_pos)
            acc_clamp = lim_pos[19:0];
        else if (acc_sum < lim_neg)
            acc_clamp = lim_neg[19:0];
        else
            acc_clamp = acc_sum[19:0];
    end

    // One restoring divide step
    assign div_fit = num_reg[63:0] >= {14'd0, dsh_reg};
    assign div_rem = num_reg - {14'd0, dsh_reg};

    // Saturate the quotient; a non-positive numerator gives zero
    always_comb
    begin
        if (!pos_reg)
            drive_next = '0;
        else if (q_reg[DIV_STEPS-1])
            drive_next = DRIVE_MAX;
        else
            drive_next = q_reg[7:0];
    end

    // Configuration writes; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RST;
            gprop_reg  <= GPROP_RST;
            ginteg_reg <= GINTEG_RST;
            gderiv_reg <= GDERIV_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_LEVEL: target_reg <= cfg_data[9:0];
                REG_GAIN_PROP:    gprop_reg  <= cfg_data;
                REG_GAIN_INTEG:   ginteg_reg <= cfg_data;
                REG_GAIN_DERIV:   gderiv_reg <= cfg_data;
                REG_INTEG_LIMIT:  limit_reg  <= cfg_data[18:0];
                default:
                begin
                    target_reg <= target_reg;
                end
            endcase
        end
    end

    // Commit loop state when the result is handed off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            last_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            accum_reg <= acc_new_reg;
            last_reg  <= err_reg;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load)
        begin
            el_reg  <= in_elapsed_ms;
            err_reg <= $signed({1'b0, target_reg}) - $signed({1'b0, in_sample});
            num_reg <= '0;
            q_reg   <= '0;
        end
        case (cmd.wr_sel)
            WR_ACC:    acc_new_reg <= acc_clamp;
            WR_G:      g_reg       <= prod_reg[39:0];
            WR_H:      h_reg       <= prod_reg[39:0];
            WR_E1K:    e1k_reg     <= prod_reg[20:0];
            WR_D1M:    d1m_reg     <= prod_reg[31:0];
            WR_NUM:    num_reg     <= num_reg + $signed(prod_reg[63:0]);
            WR_NUM_HI: num_reg     <= num_reg + $signed({prod_reg[43:0], 20'd0});
            WR_DEN:
            begin
                dsh_reg <= {prod_reg[25:0], 24'd0};
                pos_reg <= !num_reg[63] && (num_reg != '0);
            end
            default: ;
        endcase
        if (cmd.div_step)
        begin
            if (div_fit)
            begin
                num_reg <= $signed(div_rem);
                q_reg   <= {q_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[DIV_STEPS-2:0], 1'b0};
            end
            dsh_reg <= {1'b0, dsh_reg[49:1]};
        end
        if (cmd.commit)
            drive_reg <= drive_next;
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign sts.el_zero  = (in_elapsed_ms == '0);
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_drive    = drive_reg;

endmodule

@@ rtl/core/pid_controller_clamped.sv @@
// The drive is computed by the eleven products of the shared 33x33 multiplier
// and the nine-step restoring divide; a new sample is taken only once the last
// result has been handed off to the output register, and an item with zero
// elapsed time is dropped in its transfer cycle.
// Reset (rst_n low, asynchronous): configuration registers return to their defaults,
// accumulated and previous error clear to zero, no result is pending.
module pid_controller_clamped
    import pidc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pidc_meas_if.sink             meas,
    pidc_duty_if.source           duty,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    pidc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (meas.valid),
        .in_ready (meas.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pidc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_sample     (meas.sample),
        .in_elapsed_ms (meas.elapsed_ms),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (duty.ready),
        .out_valid     (duty.valid),
        .out_drive     (duty.drive)
    );

endmodule

@@ rtl/core/pidc_checker.sv @@
module pidc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        meas_valid,
    input logic        meas_ready,
    input logic [15:0] meas_elapsed_ms,
    input logic        duty_valid,
    input logic        duty_ready,
    input logic [7:0]  duty_drive
);

    logic take_item;
    logic take_skip;

    assign take_item = meas_valid && meas_ready && (meas_elapsed_ms != '0);
    assign take_skip = meas_valid && meas_ready && (meas_elapsed_ms == '0);

    // Hold a stalled result
    a_duty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid && !duty_ready |=> duty_valid && $stable(duty_drive))
        else $error("drive changed or dropped while stalled");

    // Block takes no new item while one is in work
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take_item |=> !meas_ready)
        else $error("input ready right after a transfer");

    // Zero elapsed time is dropped at once
    a_skip_ready: assert property (@(posedge clk) disable iff (!rst_n)
        take_skip |=> meas_ready)
        else $error("zero elapsed time item not dropped");

    // No result appears right after a transfer
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        take_item |=> !$rose(duty_valid))
        else $error("result raised too early");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .meas_valid      (meas.valid),
    .meas_ready      (meas.ready),
    .meas_elapsed_ms (meas.elapsed_ms),
    .duty_valid      (duty.valid),
    .duty_ready      (duty.ready),
    .duty_drive      (duty.drive)
);

@@ verif/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 30;

    // Tracks loop state and configuration, predicts the drive for each sample with nonzero elapsed time
    class duty_tracker;
        logic [9:0]         setpoint;
        logic [23:0]        kp;
        logic [23:0]        ki;
        logic [23:0]        kd;
        logic [18:0]        windup_lim;
        logic signed [19:0] integ_sum;
        logic signed [10:0] prev_err;
        logic [7:0]         expected_duty[$];
        int                 failures;
        int                 checked;
        int                 skipped;
        int                 reg_writes;

        function new();
            setpoint   = TARGET_RST;
            kp         = GPROP_RST;
            ki         = GINTEG_RST;
            kd         = GDERIV_RST;
            windup_lim = LIMIT_RST;
            integ_sum  = '0;
            prev_err   = '0;
            failures   = 0;
            checked    = 0;
            skipped    = 0;
            reg_writes = 0;
        endfunction

        // Apply one register write; unknown indexes drop, wide data truncates
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                REG_TARGET_LEVEL: setpoint   = data[9:0];
                REG_GAIN_PROP:    kp         = data;
                REG_GAIN_INTEG:   ki         = data;
                REG_GAIN_DERIV:   kd         = data;
                REG_INTEG_LIMIT:  windup_lim = data[18:0];
                default: ;
            endcase
        endfunction

        // Advance the loop by one accepted sample and queue the expected drive; zero elapsed time only counts a skip
        function void note_sample(logic [9:0] smp, logic [15:0] el);
            longint err;
            longint elv;
            longint acc;
            longint lim;
            longint num;
            longint den;
            longint q;
            if (el == 16'd0)
            begin
                skipped++;
                return;
            end
            elv = longint'(el);
            err = longint'(setpoint) - longint'(smp);
            lim = longint'(windup_lim);
            acc = longint'(integ_sum) + err * elv;
            if (acc > lim)
                acc = lim;
            if (acc < -lim)
                acc = -lim;
            num = longint'(kp) * err * 1000 * elv
                + longint'(ki) * acc * elv
                + longint'(kd) * (err - longint'(prev_err)) * 1000000;
            den = 65536 * 1000 * elv;
            if (num <= 0)
                q = 0;
            else
            begin
                q = num / den;
                if (q > 255)
                    q = 255;
            end
            integ_sum = acc[19:0];
            prev_err  = err[10:0];
            expected_duty.push_back(q[7:0]);
        endfunction

        // Compare one delivered drive with the oldest prediction
        function void check_duty(logic [7:0] got);
            logic [7:0] want;
            if (expected_duty.size() == 0)
            begin
                $error("drive: none expected, got %0d", got);
                failures++;
                return;
            end
            want = expected_duty.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("drive: expected %0d, got %0d", want, got);
                failures++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pidc_meas_if meas();
    pidc_duty_if duty();

    duty_tracker tracker = new();

    int cycle_count    = 0;
    int burst_left     = 0;
    int items_sent     = 0;
    int holdoff_grants = 0;
    int holdoff_served = 0;
    int phase_count    = 0;

    pid_controller_clamped dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .meas      (meas),
        .duty      (duty),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[pid_controller_clamped] ERROR");
            $finish;
        end
    end

    // Track register writes, sample transfers and drive transfers
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_we === 1'b1)
                tracker.write_reg(cfg_index, cfg_data);
            if (meas.valid === 1'b1 && meas.ready === 1'b1)
                tracker.note_sample(meas.sample, meas.elapsed_ms);
            if (duty.valid === 1'b1 && duty.ready === 1'b1)
                tracker.check_duty(duty.drive);
        end
    end

    // Drive the result side: random stall modes plus requested long hold-offs
    initial
    begin : receiver
        int mode;
        int mode_left;
        mode       = 0;
        mode_left  = 0;
        duty.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holdoff_served != holdoff_grants)
            begin
                holdoff_served++;
                duty.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       duty.ready <= 1'b1;
                    1:       duty.ready <= 1'($urandom_range(0, 1));
                    2:       duty.ready <= ($urandom_range(0, 3) == 0);
                    default: duty.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one sample, hold it until transfer, then maybe close the burst
    task automatic offer(input logic [9:0] smp, input logic [15:0] el, input bit last);
        int gap;
        meas.valid      <= 1'b1;
        meas.sample     <= smp;
        meas.elapsed_ms <= el;
        @(posedge clk);
        while (meas.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
        else
            burst_left--;
        if (last || gap > 0)
            meas.valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // Write one register; the caller lowers the enable after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Wait for every predicted drive, then for the pipeline to drain
    task automatic settle();
        // let the monitor record the last sample transfer first
        @(posedge clk);
        while (tracker.expected_duty.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(0, 24'h00FFFF));
            3, 4:    return 24'($urandom_range(0, 24'h03FFFF));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [18:0] pick_limit();
        case ($urandom_range(0, 4))
            0:       return 19'd0;
            1:       return 19'h7FFFF;
            2:       return 19'($urandom_range(0, 5000));
            default: return 19'($urandom);
        endcase
    endfunction

    // Program a register set: all-max, all-zero, or random values
    task automatic configure(input int phase);
        logic [23:0] junk;
        junk = 24'($urandom);
        if (phase == 0)
        begin
            write_reg(REG_TARGET_LEVEL, 24'hFFFFFF);
            write_reg(REG_GAIN_PROP,    24'hFFFFFF);
            write_reg(REG_GAIN_INTEG,   24'hFFFFFF);
            write_reg(REG_GAIN_DERIV,   24'hFFFFFF);
            write_reg(REG_INTEG_LIMIT,  24'hFFFFFF);
        end
        else if (phase == 1)
        begin
            write_reg(REG_TARGET_LEVEL, {junk[23:10], 10'd0});
            write_reg(REG_GAIN_PROP,    24'd0);
            write_reg(REG_GAIN_INTEG,   24'd0);
            write_reg(REG_GAIN_DERIV,   24'd0);
            write_reg(REG_INTEG_LIMIT,  {junk[23:19], 19'd0});
        end
        else
        begin
            write_reg(REG_TARGET_LEVEL, {junk[23:10], 10'($urandom_range(0, 1023))});
            write_reg(REG_GAIN_PROP,    pick_gain());
            write_reg(REG_GAIN_INTEG,   pick_gain());
            write_reg(REG_GAIN_DERIV,   pick_gain());
            write_reg(REG_INTEG_LIMIT,  {junk[23:19], pick_limit()});
        end
        // Unmapped index: must not disturb any register
        write_reg(CFG_IDX_W'($urandom_range(5, 7)), 24'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
        phase_count++;
    endtask

    function automatic logic [9:0] pick_sample();
        int s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                s = int'(tracker.setpoint) + $urandom_range(0, 60) - 30;
                if (s < 0)
                    s = 0;
                if (s > 1023)
                    s = 1023;
                return 10'(s);
            end
            5, 6, 7: return 10'($urandom);
            8:       return 10'd0;
            default: return 10'd1023;
        endcase
    endfunction

    function automatic logic [15:0] pick_elapsed();
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(1, 200));
        endcase
    endfunction

    initial
    begin : stimulus
        logic [9:0]  d_smp[18];
        logic [15:0] d_el[18];
        int          n;
        d_smp = '{10'd500, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd0,
                  10'd0, 10'd600, 10'd490, 10'd495, 10'd505, 10'd500, 10'd1023,
                  10'd250, 10'd750, 10'd511};
        d_el  = '{16'd10, 16'd1, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd65535,
                  16'd65535, 16'd1, 16'd1, 16'd100, 16'd1000, 16'd20, 16'd0,
                  16'd3, 16'd32768, 16'd255, 16'd50};

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        meas.valid      = 1'b0;
        meas.sample     = '0;
        meas.elapsed_ms = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples at reset gains: zero error, both clamps, skips
        for (int i = 0; i < 18; i++)
            offer(d_smp[i], d_el[i], i == 17);
        settle();

        // Random phases, two of them under a long result hold-off
        for (int ph = 0; ph < 7; ph++)
        begin
            configure(ph);
            if (ph == 3 || ph == 5)
                holdoff_grants++;
            n = (ph < 2) ? 40 : 115;
            for (int i = 0; i < n; i++)
                offer(pick_sample(), pick_elapsed(), i == n - 1);
            settle();
        end

        $display("Covered %0d samples (%0d with zero elapsed time) over %0d register sets.",
                 items_sent, tracker.skipped, phase_count + 1);
        $display("Checked %0d drive values after %0d register writes.",
                 tracker.checked, tracker.reg_writes);
        if (tracker.failures == 0)
            $display("[pid_controller_clamped] OK");
        else
            $display("[pid_controller_clamped] ERROR");
        $finish;
    end

endmodule
